@@ src/adt_pkg.sv @@
// ----------------------------------------------------------------------------
// adt_pkg: shared definitions for the packed word table
// Command codes, status codes, sequencer states and the control bundle that
// the sequencer broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package adt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int WORD_W       = 32;
  localparam int IDX_W        = 6;
  localparam int LEN_W        = 7;

  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_DEL_AT  = 3'd1;
  localparam logic [2:0] CMD_DROP    = 3'd2;
  localparam logic [2:0] CMD_KEEP    = 3'd3;
  localparam logic [2:0] CMD_DEL_VAL = 3'd4;
  localparam logic [2:0] CMD_DEDUP   = 3'd5;
  localparam logic [2:0] CMD_READ    = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    MK_INDEX,
    MK_BEFORE,
    MK_VALUE,
    MK_AFTER_EQ
  } mark_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMPACT,
    S_DUP_MARK,
    S_RESP,
    S_READ
  } state_t;

  typedef struct packed {
    logic              write;
    logic              mark;
    logic              compact;
    mark_mode_t        mode;
    logic [IDX_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] value;
  } cell_ctl_t;

endpackage

@@ src/adt_cell.sv @@
// ----------------------------------------------------------------------------
// adt_cell: one slot of the table
// Holds a word and a removal mark. On a compaction step the cell takes the
// word and mark of its upper neighbor when any cell at or below it is marked.
// ----------------------------------------------------------------------------
module adt_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  adt_pkg::cell_ctl_t        ctl,
  input  logic [adt_pkg::WORD_W-1:0] up_word,
  input  logic                      up_dead,
  input  logic                      shift_in,
  output logic [adt_pkg::WORD_W-1:0] word,
  output logic                      dead,
  output logic                      shift_out
);

  localparam logic [adt_pkg::LEN_W-1:0] MY = adt_pkg::LEN_W'(IDX);

  logic in_range;
  logic hit;

  assign shift_out = shift_in | dead;
  assign in_range  = MY < ctl.len;

  always_comb begin
    case (ctl.mode)
      adt_pkg::MK_INDEX:    hit = MY == {1'b0, ctl.pos};
      adt_pkg::MK_BEFORE:   hit = MY < {1'b0, ctl.pos};
      adt_pkg::MK_VALUE:    hit = word == ctl.value;
      adt_pkg::MK_AFTER_EQ: hit = (MY > {1'b0, ctl.pos}) && (word == ctl.value);
      default:              hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dead <= 1'b0;
    end else if (ctl.compact && shift_out) begin
      dead <= up_dead;
    end else if (ctl.mark) begin
      dead <= in_range && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.compact && shift_out) begin
      word <= up_word;
    end else if (ctl.write && ctl.len == MY) begin
      word <= ctl.value;
    end
  end

endmodule

@@ src/adt_chain.sv @@
// ----------------------------------------------------------------------------
// adt_chain: row of table cells
// Links the cells so that words and marks move down one slot per compaction
// step, and gathers the stored words and the any-marked flag.
// ----------------------------------------------------------------------------
module adt_chain #(
  parameter int CAPACITY = adt_pkg::CAPACITY_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  adt_pkg::cell_ctl_t                       ctl,
  output logic [CAPACITY-1:0][adt_pkg::WORD_W-1:0] words,
  output logic                                     any_dead
);

  logic [CAPACITY-1:0] dead;
  logic [CAPACITY:0]   shift;

  assign shift[0] = 1'b0;
  assign any_dead = |dead;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [adt_pkg::WORD_W-1:0] up_word;
    logic                       up_dead;

    if (i == CAPACITY - 1) begin : g_top
      assign up_word = '0;
      assign up_dead = 1'b0;
    end else begin : g_mid
      assign up_word = words[i+1];
      assign up_dead = dead[i+1];
    end

    adt_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .up_word  (up_word),
      .up_dead  (up_dead),
      .shift_in (shift[i]),
      .word     (words[i]),
      .dead     (dead[i]),
      .shift_out(shift[i+1])
    );
  end

endmodule

@@ src/array_delete_and_dedup_table_core.sv @@
// ----------------------------------------------------------------------------
// array_delete_and_dedup_table_core: packed word table with deletion
// Keeps up to CAPACITY signed words packed from slot 0 in a chain of cells
// and runs append, delete, drop, keep, delete-value, dedup and read out.
//
//   channel | handshake          | fields
//   --------+--------------------+-----------------------------
//   input   | in_valid/in_ready  | cmd, position, word
//   output  | out_valid/out_ready| data, count, last, status
//
// Append, keep-through, range errors and unused codes respond straight from
// idle. Delete-at, drop-before and delete-value mark words, then compact,
// one removal per step, until no mark is left. Dedup marks later copies of
// each kept word in turn and compacts them. Read out gives one beat per cycle
// unless stalled. Reset clears state, length and marks but not the words; no
// clearing pass. A stalled output holds the sequencer; input is taken in idle.
// ----------------------------------------------------------------------------
module array_delete_and_dedup_table_core #(
  parameter int CAPACITY = adt_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          cmd,
  input  logic [adt_pkg::IDX_W-1:0]           position,
  input  logic signed [adt_pkg::WORD_W-1:0]   word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [adt_pkg::WORD_W-1:0]   data,
  output logic [adt_pkg::LEN_W-1:0]           count,
  output logic                                last,
  output logic [1:0]                          status
);

  localparam int AW = $clog2(CAPACITY);
  localparam logic [adt_pkg::LEN_W-1:0] CAP = adt_pkg::LEN_W'(CAPACITY);

  adt_pkg::state_t    state, state_next;
  adt_pkg::cell_ctl_t ctl;

  logic [adt_pkg::LEN_W-1:0] len, len_next;
  logic [adt_pkg::LEN_W-1:0] cur, cur_next;
  logic [1:0]                st_hold, st_hold_next;
  logic                      op_dup, op_dup_next;

  logic [CAPACITY-1:0][adt_pkg::WORD_W-1:0] words;
  logic                                     any_dead;

  logic                       out_free;
  logic                       ld_out;
  logic [adt_pkg::WORD_W-1:0] o_data;
  logic                       o_last;
  logic [adt_pkg::LEN_W-1:0]  pos_ext;

  adt_chain #(
    .CAPACITY(CAPACITY)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .words   (words),
    .any_dead(any_dead)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = state == adt_pkg::S_IDLE;
  assign pos_ext  = {1'b0, position};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= adt_pkg::S_IDLE;
      len    <= '0;
      cur    <= '0;
      op_dup <= 1'b0;
    end else begin
      state  <= state_next;
      len    <= len_next;
      cur    <= cur_next;
      op_dup <= op_dup_next;
    end
  end

  always_ff @(posedge clk) begin
    st_hold <= st_hold_next;
  end

  always_comb begin
    state_next   = state;
    len_next     = len;
    cur_next     = cur;
    st_hold_next = st_hold;
    op_dup_next  = op_dup;
    ctl          = '0;
    ld_out       = 1'b0;
    o_data       = '0;
    o_last       = 1'b1;
    case (state)
      adt_pkg::S_IDLE: begin
        if (in_valid) begin
          st_hold_next = adt_pkg::ST_OK;
          op_dup_next  = 1'b0;
          state_next   = adt_pkg::S_RESP;
          case (cmd)
            adt_pkg::CMD_APPEND: begin
              if (len >= CAP) begin
                st_hold_next = adt_pkg::ST_FULL;
              end else begin
                ctl.write = 1'b1;
                ctl.len   = len;
                ctl.value = word;
                len_next  = len + 1'b1;
              end
            end
            adt_pkg::CMD_DEL_AT: begin
              if (pos_ext >= len) begin
                st_hold_next = adt_pkg::ST_RANGE;
              end else begin
                ctl.mark   = 1'b1;
                ctl.mode   = adt_pkg::MK_INDEX;
                ctl.pos    = position;
                ctl.len    = len;
                state_next = adt_pkg::S_COMPACT;
              end
            end
            adt_pkg::CMD_DROP: begin
              ctl.mark   = 1'b1;
              ctl.mode   = adt_pkg::MK_BEFORE;
              ctl.pos    = position;
              ctl.len    = len;
              state_next = adt_pkg::S_COMPACT;
            end
            adt_pkg::CMD_KEEP: begin
              if (pos_ext + 1'b1 < len) begin
                len_next = pos_ext + 1'b1;
              end
            end
            adt_pkg::CMD_DEL_VAL: begin
              ctl.mark   = 1'b1;
              ctl.mode   = adt_pkg::MK_VALUE;
              ctl.len    = len;
              ctl.value  = word;
              state_next = adt_pkg::S_COMPACT;
            end
            adt_pkg::CMD_DEDUP: begin
              op_dup_next = 1'b1;
              cur_next    = '0;
              state_next  = adt_pkg::S_DUP_MARK;
            end
            adt_pkg::CMD_READ: begin
              cur_next   = '0;
              state_next = adt_pkg::S_READ;
            end
            default: begin
              state_next = adt_pkg::S_RESP;
            end
          endcase
        end
      end
      adt_pkg::S_COMPACT: begin
        if (any_dead) begin
          ctl.compact = 1'b1;
          len_next    = len - 1'b1;
        end else if (op_dup) begin
          cur_next   = cur + 1'b1;
          state_next = adt_pkg::S_DUP_MARK;
        end else begin
          state_next = adt_pkg::S_RESP;
        end
      end
      adt_pkg::S_DUP_MARK: begin
        if (cur < len) begin
          ctl.mark   = 1'b1;
          ctl.mode   = adt_pkg::MK_AFTER_EQ;
          ctl.pos    = cur[adt_pkg::IDX_W-1:0];
          ctl.len    = len;
          ctl.value  = words[cur[AW-1:0]];
          state_next = adt_pkg::S_COMPACT;
        end else begin
          state_next = adt_pkg::S_RESP;
        end
      end
      adt_pkg::S_RESP: begin
        if (out_free) begin
          ld_out     = 1'b1;
          state_next = adt_pkg::S_IDLE;
        end
      end
      adt_pkg::S_READ: begin
        if (out_free) begin
          ld_out = 1'b1;
          if (len == '0) begin
            state_next = adt_pkg::S_IDLE;
          end else begin
            o_data   = words[cur[AW-1:0]];
            o_last   = (cur + 1'b1) == len;
            cur_next = cur + 1'b1;
            if (o_last) begin
              state_next = adt_pkg::S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = adt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      data   <= o_data;
      count  <= len;
      last   <= o_last;
      status <= (state == adt_pkg::S_RESP) ? st_hold : adt_pkg::ST_OK;
    end
  end

endmodule

@@ verif/array_delete_and_dedup_table_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_delete_and_dedup_table_core_tb: self-checking bench for the word table
// Drives table commands through the input channel with random gaps, keeps a
// shadow copy of the packed table to predict every output beat, and compares
// each accepted beat field by field while the receiver stalls at random.
// ----------------------------------------------------------------------------
module array_delete_and_dedup_table_core_tb;

  localparam int         CAP        = adt_pkg::CAPACITY_DEF;
  localparam logic [2:0] CMD_NOP    = 3'd7;
  localparam int         CYCLE_CAP  = 600000;

  typedef struct packed {
    logic signed [adt_pkg::WORD_W-1:0] data;
    logic [adt_pkg::LEN_W-1:0]         count;
    logic                              last;
    logic [1:0]                        status;
  } beat_t;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  logic [2:0]                        cmd       = '0;
  logic [adt_pkg::IDX_W-1:0]         position  = '0;
  logic signed [adt_pkg::WORD_W-1:0] word      = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [adt_pkg::WORD_W-1:0] data;
  logic [adt_pkg::LEN_W-1:0]         count;
  logic                              last;
  logic [1:0]                        status;

  logic signed [adt_pkg::WORD_W-1:0] shadow_words [CAP];
  int                                shadow_len = 0;
  beat_t                             expected_beats [$];
  int                                error_count = 0;
  int                                cycle_count = 0;
  bit                                tx_no_idle = 1'b0;
  bit                                rx_no_idle = 1'b0;
  int                                rx_hold = 0;
  beat_t                             seen_beat;
  beat_t                             want_beat;

  array_delete_and_dedup_table_core #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .position(position), .word(word),
    .out_valid(out_valid), .out_ready(out_ready),
    .data(data), .count(count), .last(last), .status(status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("array_delete_and_dedup_table_core_tb: errors");
      $finish;
    end
  end

  function automatic beat_t make_beat(logic signed [adt_pkg::WORD_W-1:0] d, logic l,
                                      logic [1:0] s);
    beat_t b;
    b.data   = d;
    b.count  = shadow_len[adt_pkg::LEN_W-1:0];
    b.last   = l;
    b.status = s;
    return b;
  endfunction

  task automatic shadow_remove(input int idx);
    for (int i = idx; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i + 1];
    shadow_len--;
  endtask

  task automatic shadow_table_exec(input logic [2:0] c, input logic [adt_pkg::IDX_W-1:0] p,
                                   input logic signed [adt_pkg::WORD_W-1:0] w);
    logic [1:0] st;
    int         j;
    st = adt_pkg::ST_OK;
    case (c)
      adt_pkg::CMD_APPEND: begin
        if (shadow_len >= CAP) begin
          st = adt_pkg::ST_FULL;
        end else begin
          shadow_words[shadow_len] = w;
          shadow_len++;
        end
      end
      adt_pkg::CMD_DEL_AT: begin
        if (int'(p) >= shadow_len) st = adt_pkg::ST_RANGE;
        else shadow_remove(int'(p));
      end
      adt_pkg::CMD_DROP: begin
        if (int'(p) >= shadow_len) begin
          shadow_len = 0;
        end else begin
          for (int i = int'(p); i < shadow_len; i++) shadow_words[i - int'(p)] = shadow_words[i];
          shadow_len -= int'(p);
        end
      end
      adt_pkg::CMD_KEEP: begin
        if (int'(p) + 1 < shadow_len) shadow_len = int'(p) + 1;
      end
      adt_pkg::CMD_DEL_VAL: begin
        j = 0;
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_words[i] != w) begin
            shadow_words[j] = shadow_words[i];
            j++;
          end
        end
        shadow_len = j;
      end
      adt_pkg::CMD_DEDUP: begin
        for (int i = 0; i < shadow_len; i++) begin
          j = i + 1;
          while (j < shadow_len) begin
            if (shadow_words[j] == shadow_words[i]) shadow_remove(j);
            else j++;
          end
        end
      end
      default: ;
    endcase
    if (c == adt_pkg::CMD_READ && shadow_len != 0) begin
      for (int i = 0; i < shadow_len; i++)
        expected_beats.push_back(make_beat(shadow_words[i], i + 1 == shadow_len,
                                           adt_pkg::ST_OK));
    end else begin
      expected_beats.push_back(make_beat('0, 1'b1, st));
    end
  endtask

  // Called right after a rising edge; returns right after the edge that took the beat.
  task automatic send_item(input logic [2:0] c, input logic [adt_pkg::IDX_W-1:0] p,
                           input logic signed [adt_pkg::WORD_W-1:0] w);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    position <= p;
    word     <= w;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    shadow_table_exec(c, p, w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [adt_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0000_0005;
      5: return 32'h0000_002A;
      6: return 32'hDEAD_BEEF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_command(input bit wellformed);
    int                        r;
    logic [2:0]                c;
    logic [adt_pkg::IDX_W-1:0] p;
    r = $urandom_range(0, 99);
    if (!wellformed) c = 3'($urandom_range(0, 7));
    else if (r < 40) c = adt_pkg::CMD_APPEND;
    else if (r < 50) c = adt_pkg::CMD_DEL_AT;
    else if (r < 55) c = adt_pkg::CMD_DROP;
    else if (r < 60) c = adt_pkg::CMD_KEEP;
    else if (r < 70) c = adt_pkg::CMD_DEL_VAL;
    else if (r < 78) c = adt_pkg::CMD_DEDUP;
    else if (r < 97) c = adt_pkg::CMD_READ;
    else c = CMD_NOP;
    if ($urandom_range(0, 3) == 0) p = adt_pkg::IDX_W'($urandom_range(0, 63));
    else p = adt_pkg::IDX_W'($urandom_range(0, shadow_len));
    send_item(c, p, pick_word());
  endtask

  task automatic test_directed();
    send_item(adt_pkg::CMD_READ,    6'd0,  32'sd0);
    send_item(adt_pkg::CMD_DEDUP,   6'd0,  32'sd0);
    send_item(adt_pkg::CMD_DEL_VAL, 6'd0,  32'sd0);
    send_item(adt_pkg::CMD_KEEP,    6'd0,  32'sd0);
    send_item(adt_pkg::CMD_DROP,    6'd0,  32'sd0);
    send_item(adt_pkg::CMD_DEL_AT,  6'd0,  32'sd0);
    send_item(CMD_NOP,              6'd63, 32'hFFFF_FFFF);
    send_item(adt_pkg::CMD_APPEND,  6'd0,  32'h8000_0000);
    send_item(adt_pkg::CMD_APPEND,  6'd63, 32'h7FFF_FFFF);
    send_item(adt_pkg::CMD_APPEND,  6'd0,  32'h0000_0000);
    send_item(adt_pkg::CMD_APPEND,  6'd0,  32'hFFFF_FFFF);
    send_item(adt_pkg::CMD_APPEND,  6'd0,  32'h7FFF_FFFF);
    send_item(adt_pkg::CMD_APPEND,  6'd0,  32'h8000_0000);
    send_item(adt_pkg::CMD_READ,    6'd0,  32'sd0);
    send_item(adt_pkg::CMD_DEL_AT,  6'd63, 32'sd0);
    send_item(adt_pkg::CMD_KEEP,    6'd63, 32'sd0);
    send_item(adt_pkg::CMD_DEL_AT,  6'd5,  32'sd0);
    send_item(adt_pkg::CMD_DEL_AT,  6'd0,  32'sd0);
    send_item(adt_pkg::CMD_DEDUP,   6'd0,  32'sd0);
    send_item(adt_pkg::CMD_READ,    6'd0,  32'sd0);
    send_item(adt_pkg::CMD_DEL_VAL, 6'd0,  32'h7FFF_FFFF);
    send_item(adt_pkg::CMD_DROP,    6'd1,  32'sd0);
    send_item(adt_pkg::CMD_KEEP,    6'd0,  32'sd0);
    send_item(adt_pkg::CMD_DROP,    6'd63, 32'sd0);
    send_item(adt_pkg::CMD_READ,    6'd0,  32'sd0);
  endtask

  task automatic test_fill_overflow();
    while (shadow_len < CAP)
      send_item(adt_pkg::CMD_APPEND, adt_pkg::IDX_W'($urandom_range(0, 63)), pick_word());
    send_item(adt_pkg::CMD_APPEND, 6'd0, $urandom);
    send_item(adt_pkg::CMD_APPEND, 6'd0, $urandom);
    send_item(adt_pkg::CMD_READ, 6'd0, 32'sd0);
    send_item(adt_pkg::CMD_DEL_AT, adt_pkg::IDX_W'(CAP - 1), 32'sd0);
    send_item(adt_pkg::CMD_DEL_AT, adt_pkg::IDX_W'(CAP - 1), 32'sd0);
    send_item(adt_pkg::CMD_APPEND, 6'd0, pick_word());
    send_item(adt_pkg::CMD_DEDUP, 6'd0, 32'sd0);
    send_item(adt_pkg::CMD_READ, 6'd0, 32'sd0);
  endtask

  task automatic test_random_mix();
    repeat (200) random_command($urandom_range(0, 9) != 0);
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    repeat (50) random_command(1'b1);
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    repeat (130) random_command($urandom_range(0, 9) != 0);
  endtask

  task automatic test_output_backpressure();
    rx_hold    = 150;
    tx_no_idle = 1'b1;
    repeat (16) send_item(adt_pkg::CMD_APPEND, 6'd0, pick_word());
    send_item(adt_pkg::CMD_READ, 6'd0, 32'sd0);
    send_item(adt_pkg::CMD_DEDUP, 6'd0, 32'sd0);
    send_item(adt_pkg::CMD_READ, 6'd0, 32'sd0);
    send_item(adt_pkg::CMD_DEL_VAL, 6'd0, pick_word());
    tx_no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_pause_resume();
    repeat (10) random_command(1'b1);
    wait_drained();
    repeat (10) random_command(1'b1);
    wait_drained();
  endtask

  initial begin : receiver
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = rx_no_idle ? 0 : $urandom_range(0, 8);
      if (rx_hold != 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  // The next rising edge takes a beat whenever both sides are high at the falling edge.
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_beat = '{data: data, count: count, last: last, status: status};
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat data %0d count %0d last %0d status %0d",
                 $time, data, count, last, status);
        error_count++;
      end else begin
        want_beat = expected_beats.pop_front();
        if (seen_beat !== want_beat) begin
          $display({"%0t: expected data %0d count %0d last %0d status %0d, ",
                    "got data %0d count %0d last %0d status %0d"},
                   $time, want_beat.data, want_beat.count, want_beat.last,
                   want_beat.status, seen_beat.data, seen_beat.count,
                   seen_beat.last, seen_beat.status);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_overflow();
    test_random_mix();
    test_output_backpressure();
    test_pause_resume();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("array_delete_and_dedup_table_core_tb: clean");
    end else begin
      $display("array_delete_and_dedup_table_core_tb: errors");
    end
    $finish;
  end

endmodule
